// ===== rtl/core/hidrbl_pkg.sv =====
`timescale 1ns / 1ps

package hidrbl_pkg;

    // Field and storage widths.
    localparam int BYTE_W    = 8;
    localparam int TOTAL_W   = 32;
    localparam int TAG_W     = 4;
    localparam int REM_W     = 8;
    localparam int IDX_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REPORT_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAIN_TAG  = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] RESET_REPORT_ID = 8'd0;
    localparam logic [TAG_W-1:0]  RESET_MAIN_TAG  = 4'd8;

    // Item prefix decoding.
    localparam logic [BYTE_W-1:0] LONG_PREFIX      = 8'hFE;
    localparam logic [1:0]        SIZE_CODE_FOUR   = 2'd3;
    localparam logic [1:0]        TYPE_MAIN        = 2'd0;
    localparam logic [1:0]        TYPE_GLOBAL      = 2'd1;
    localparam logic [TAG_W-1:0]  TAG_REPORT_SIZE  = 4'd7;
    localparam logic [TAG_W-1:0]  TAG_REPORT_ID    = 4'd8;
    localparam logic [TAG_W-1:0]  TAG_REPORT_COUNT = 4'd9;

    typedef enum logic [3:0] {
        PH_PREFIX    = 4'b0001,
        PH_SHORT     = 4'b0010,
        PH_LONG_HDR  = 4'b0100,
        PH_LONG_SKIP = 4'b1000
    } phase_t;

    // What the parser hands to the accumulate stage for one word.
    typedef struct packed {
        logic               add;
        logic               last;
        logic               trunc;
        logic [TOTAL_W-1:0] product;
    } stage_t;

endpackage

// ===== rtl/core/hidrbl_parser.sv =====
`timescale 1ns / 1ps

module hidrbl_parser
    import hidrbl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [BYTE_W-1:0] desc_byte,
    input  logic              last_byte,
    input  logic [BYTE_W-1:0] target_report_id,
    input  logic [TAG_W-1:0]  target_main_tag,
    output stage_t            stage
);

    phase_t              phase_reg, phase_next;
    logic [REM_W-1:0]    rem_reg, rem_next, rem_dec;
    logic [BYTE_W-1:0]   prefix_reg, prefix_next;
    logic [TOTAL_W-1:0]  value_reg, value_next, value_or;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TOTAL_W-1:0]  size_reg, size_next;
    logic [TOTAL_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]   id_reg, id_next;
    logic                finish;
    logic [BYTE_W-1:0]   fin_prefix;
    logic [TOTAL_W-1:0]  fin_value;
    logic [1:0]          fin_kind;
    logic [TAG_W-1:0]    fin_tag;
    logic [2:0]          short_len;
    logic                add;

    always_comb begin
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        prefix_next = prefix_reg;
        value_next  = value_reg;
        idx_next    = idx_reg;
        size_next   = size_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        finish      = 1'b0;
        fin_prefix  = prefix_reg;
        fin_value   = value_reg;
        rem_dec     = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
        value_or    = value_reg
                    | ({{(TOTAL_W-BYTE_W){1'b0}}, desc_byte} << {idx_reg, 3'b000});
        short_len   = (desc_byte[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, desc_byte[1:0]};
        add         = 1'b0;

        case (phase_reg)
            PH_PREFIX: begin
                if (desc_byte == LONG_PREFIX) begin
                    phase_next = PH_LONG_HDR;
                    idx_next   = '0;
                end else begin
                    prefix_next = desc_byte;
                    value_next  = '0;
                    idx_next    = '0;
                    if (short_len == 3'd0) begin
                        finish     = 1'b1;
                        fin_prefix = desc_byte;
                        fin_value  = '0;
                    end else begin
                        rem_next   = {{(REM_W-3){1'b0}}, short_len};
                        phase_next = PH_SHORT;
                    end
                end
            end
            PH_SHORT: begin
                value_next = value_or;
                idx_next   = idx_reg + 1'b1;
                rem_next   = rem_dec;
                if (rem_dec == '0) begin
                    finish    = 1'b1;
                    fin_value = value_or;
                end
            end
            PH_LONG_HDR: begin
                if (idx_reg == '0) begin
                    rem_next = desc_byte;
                    idx_next = {{(IDX_W-1){1'b0}}, 1'b1};
                end else begin
                    idx_next   = '0;
                    phase_next = (rem_reg == '0) ? PH_PREFIX : PH_LONG_SKIP;
                end
            end
            PH_LONG_SKIP: begin
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_PREFIX;
                end
            end
            default: begin
                phase_next = PH_PREFIX;
            end
        endcase

        fin_kind = fin_prefix[3:2];
        fin_tag  = fin_prefix[7:4];
        if (finish) begin
            phase_next = PH_PREFIX;
            if (fin_kind == TYPE_GLOBAL && fin_tag == TAG_REPORT_SIZE) begin
                size_next = fin_value;
            end else if (fin_kind == TYPE_GLOBAL && fin_tag == TAG_REPORT_ID) begin
                id_next = fin_value[BYTE_W-1:0];
            end else if (fin_kind == TYPE_GLOBAL && fin_tag == TAG_REPORT_COUNT) begin
                count_next = fin_value;
            end else if (fin_kind == TYPE_MAIN && fin_tag == target_main_tag &&
                         id_reg == target_report_id) begin
                add = 1'b1;
            end
        end
    end

    // The product uses the globals as they stand before this word, which a
    // main item never changes; the sum wraps, so only the low half is kept.
    assign stage.add     = add;
    assign stage.last    = last_byte;
    assign stage.trunc   = (phase_next == PH_SHORT) || (phase_next == PH_LONG_HDR);
    assign stage.product = size_reg * count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || (load && last_byte)) begin
            phase_reg  <= PH_PREFIX;
            rem_reg    <= '0;
            prefix_reg <= '0;
            value_reg  <= '0;
            idx_reg    <= '0;
            size_reg   <= '0;
            count_reg  <= '0;
            id_reg     <= '0;
        end else if (load) begin
            phase_reg  <= phase_next;
            rem_reg    <= rem_next;
            prefix_reg <= prefix_next;
            value_reg  <= value_next;
            idx_reg    <= idx_next;
            size_reg   <= size_next;
            count_reg  <= count_next;
            id_reg     <= id_next;
        end
    end

endmodule

// ===== rtl/core/hid_report_bit_length_parser_top.sv =====
`timescale 1ns / 1ps

// HID report bit-length parser.
//
// The s_ channel carries one report descriptor byte per word, with
// s_final_byte marking the last byte of a descriptor. The m_ channel
// returns one word per descriptor: the wrapped sum of Report Size times
// Report Count over every main item of the configured tag seen under the
// configured Report ID, or zero with m_truncated set when the descriptor
// ended inside a short item's data or a long item's header.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while
// the block is idle; index 0 selects the Report ID, index 1 the main tag.
//
// A byte is accepted every cycle unless s_ready is held low as below. The
// accepting edge for a final byte loads the parse stage (decode, global
// update, size-by-count multiply); the output register is then loaded
// from the accumulator stage, which owns the running total.
// While the receiver stalls, non-final bytes keep flowing; only a final
// byte that reaches the accumulator with the output register still full
// holds s_ready low. Reset clears the parse state, the running total
// and the output valid, and restores the configuration defaults; after
// each final byte the parse state and total return to their reset values.

module hid_report_bit_length_parser_top
    import hidrbl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_descriptor_byte,
    input  logic                 s_final_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TOTAL_W-1:0]   m_report_bit_total,
    output logic                 m_truncated,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata
);

    logic [BYTE_W-1:0]  target_id_reg;
    logic [TAG_W-1:0]   target_tag_reg;
    stage_t             parse_out;
    stage_t             p_reg;
    logic               p_valid_reg;
    logic               p_take;
    logic               s_accept;
    logic [TOTAL_W-1:0] acc_reg;
    logic [TOTAL_W-1:0] acc_sum;
    logic               m_valid_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    logic               m_trunc_reg;

    // Configuration registers; writes to unused indexes fall away.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_id_reg  <= RESET_REPORT_ID;
            target_tag_reg <= RESET_MAIN_TAG;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IDX_REPORT_ID: target_id_reg  <= cfg_wdata;
                CFG_IDX_MAIN_TAG:  target_tag_reg <= cfg_wdata[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    // The parse stage always moves when the accumulator takes its word. A
    // non-final word is always taken; a final one waits for the output
    // register to be free or draining.
    assign p_take   = p_valid_reg && (!p_reg.last || !m_valid_reg || m_ready);
    assign s_ready  = !p_valid_reg || p_take;
    assign s_accept = s_valid && s_ready;

    hidrbl_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (s_accept),
        .desc_byte        (s_descriptor_byte),
        .last_byte        (s_final_byte),
        .target_report_id (target_id_reg),
        .target_main_tag  (target_tag_reg),
        .stage            (parse_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p_valid_reg <= 1'b1;
        end else if (p_take) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_reg <= parse_out;
        end
    end

    // Accumulator stage: adds the registered product when the item matched.
    assign acc_sum = acc_reg + (p_reg.add ? p_reg.product : {TOTAL_W{1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (p_take) begin
            acc_reg <= p_reg.last ? {TOTAL_W{1'b0}} : acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p_take && p_reg.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_take && p_reg.last) begin
            m_total_reg <= p_reg.trunc ? {TOTAL_W{1'b0}} : acc_sum;
            m_trunc_reg <= p_reg.trunc;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_report_bit_total = m_total_reg;
    assign m_truncated        = m_trunc_reg;

    // A truncated descriptor always reports a zero total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_truncated) |-> (m_report_bit_total == '0))
        else $error("truncated result carries a nonzero total");

    // A final byte blocked at a full output register must stall the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && p_reg.last && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while a final byte is blocked");

    // The running total starts from zero after every descriptor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p_take && p_reg.last) |=> (acc_reg == '0))
        else $error("accumulator not cleared after a final byte");

    // A new result appears only when a final byte left the parse stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(p_take && p_reg.last))
        else $error("result word without a final byte");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the HID report bit-length parser. Descriptor bytes go in on the s_
// channel; every final byte brings back one word on the m_ channel. A local model of the
// parser tracks the item decode, the globals and the running total, and it queues the word
// that each final byte should produce. Result words are checked in order against that queue.

module tb_top;
    import hidrbl_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 5;
    localparam int DIRECTED_ROWS = 27;

    // Register indexes beyond the two real registers; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = 2'd3;

    // Item types and size codes that the package leaves unnamed.
    localparam logic [1:0] TYPE_LOCAL     = 2'd2;
    localparam logic [1:0] SIZE_CODE_NONE = 2'd0;

    // Main item tags other than Input.
    localparam logic [TAG_W-1:0] MAIN_TAG_OUTPUT  = 4'd9;
    localparam logic [TAG_W-1:0] MAIN_TAG_FEATURE = 4'd11;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               trunc;
    } report_total_t;

    // One row of the directed table. Where typed is set, the final byte's result is given
    // here directly; otherwise the parser model supplies it.
    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic               typed;
        logic               trunc;
        logic [TOTAL_W-1:0] total;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Size 8, count 3, a reserved-type item that must be ignored, then an Input item
        // with one data byte and an Input item with none on the final byte.
        '{8'h75, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h08, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h95, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h03, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h8D, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h55, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h81, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h02, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 32'd0},
        // A four-byte Report Size of all ones, so the product wraps, then a long item
        // whose data runs past the final byte. That is not a truncation.
        '{8'h77, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h95, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h02, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFE, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h05, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 32'd0},
        // A short item that ends right after its prefix is truncated.
        '{8'h75, 1'b1, 1'b1, 1'b1, 32'd0},
        // A long item that ends after its size byte is truncated as well.
        '{8'hFE, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h04, 1'b1, 1'b1, 1'b1, 32'd0},
        // A long item header that completes on the final byte gives the total.
        '{8'hFE, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h02, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 32'd0}
    };

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_descriptor_byte = '0;
    logic                 s_final_byte      = 1'b0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [TOTAL_W-1:0]   m_report_bit_total;
    logic                 m_truncated;
    logic                 cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index         = '0;
    logic [BYTE_W-1:0]    cfg_wdata         = '0;

    hid_report_bit_length_parser_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_descriptor_byte  (s_descriptor_byte),
        .s_final_byte       (s_final_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_report_bit_total (m_report_bit_total),
        .m_truncated        (m_truncated),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Words that the block still owes, oldest first.
    report_total_t     pending_totals[$];
    logic [BYTE_W-1:0] descriptor_bytes[$];
    int                fail_count  = 0;
    int                cycle_count = 0;
    // While set, neither side idles, so the block sees back-to-back traffic.
    logic              steady_flow = 1'b0;

    // Model of the parser: its own copy of the filter registers and the parse state.
    logic [BYTE_W-1:0]  want_report_id;
    logic [TAG_W-1:0]   want_main_tag;
    phase_t             scan_phase;
    logic [8:0]         left_count;
    logic [BYTE_W-1:0]  open_prefix;
    logic [31:0]        open_value;
    logic [IDX_W-1:0]   byte_pos;
    logic [31:0]        cur_size;
    logic [31:0]        cur_count;
    logic [BYTE_W-1:0]  cur_id;
    logic [TOTAL_W-1:0] bit_sum;

    function automatic bit idle_roll();
        return !steady_flow && ($urandom_range(0, 99) < 33);
    endfunction

    // Everything that a final byte resets. The filter registers are kept.
    function automatic void clear_parse_state();
        scan_phase  = PH_PREFIX;
        left_count  = '0;
        open_prefix = '0;
        open_value  = '0;
        byte_pos    = '0;
        cur_size    = '0;
        cur_count   = '0;
        cur_id      = '0;
        bit_sum     = '0;
    endfunction

    function automatic void set_register(input logic [CFG_IDX_W-1:0] index,
                                         input logic [BYTE_W-1:0] data);
        case (index)
            CFG_IDX_REPORT_ID: want_report_id = data;
            CFG_IDX_MAIN_TAG:  want_main_tag  = data[TAG_W-1:0];
            default: ;
        endcase
    endfunction

    // A short item is complete: update a global, or count a matching main item.
    function automatic void close_short_item(input logic [BYTE_W-1:0] prefix,
                                             input logic [31:0] value);
        logic [1:0]       kind;
        logic [TAG_W-1:0] tag;
        kind = prefix[3:2];
        tag  = prefix[7:4];
        if (kind == TYPE_GLOBAL && tag == TAG_REPORT_SIZE) begin
            cur_size = value;
        end else if (kind == TYPE_GLOBAL && tag == TAG_REPORT_ID) begin
            cur_id = value[7:0];
        end else if (kind == TYPE_GLOBAL && tag == TAG_REPORT_COUNT) begin
            cur_count = value;
        end else if (kind == TYPE_MAIN && tag == want_main_tag && cur_id == want_report_id) begin
            bit_sum = bit_sum + cur_size * cur_count;
        end
        scan_phase = PH_PREFIX;
    endfunction

    // Moves the model on by one accepted byte; on a final byte it yields the word.
    function automatic void advance_parse(input logic [BYTE_W-1:0] data, input logic last,
                                          output logic has_result,
                                          output report_total_t result);
        logic [1:0] code;
        has_result = 1'b0;
        result     = '0;
        case (scan_phase)
            PH_PREFIX: begin
                if (data == LONG_PREFIX) begin
                    scan_phase = PH_LONG_HDR;
                    byte_pos   = '0;
                end else begin
                    code        = data[1:0];
                    open_prefix = data;
                    open_value  = '0;
                    byte_pos    = '0;
                    if (code == SIZE_CODE_NONE) begin
                        close_short_item(data, '0);
                    end else begin
                        left_count = (code == SIZE_CODE_FOUR) ? 9'd4 : {7'd0, code};
                        scan_phase = PH_SHORT;
                    end
                end
            end
            PH_SHORT: begin
                open_value = open_value | ({24'd0, data} << {byte_pos, 3'b000});
                byte_pos   = byte_pos + 1'b1;
                if (left_count != 0) left_count = left_count - 1'b1;
                if (left_count == 0) close_short_item(open_prefix, open_value);
            end
            PH_LONG_HDR: begin
                // First the length byte, then the tag byte.
                if (byte_pos == 0) begin
                    left_count = {1'b0, data};
                    byte_pos   = 2'd1;
                end else begin
                    byte_pos   = '0;
                    scan_phase = (left_count == 0) ? PH_PREFIX : PH_LONG_SKIP;
                end
            end
            default: begin
                if (left_count != 0) left_count = left_count - 1'b1;
                if (left_count == 0) scan_phase = PH_PREFIX;
            end
        endcase
        if (last) begin
            has_result = 1'b1;
            if (scan_phase == PH_SHORT || scan_phase == PH_LONG_HDR) begin
                result.total = '0;
                result.trunc = 1'b1;
            end else begin
                result.total = bit_sum;
                result.trunc = 1'b0;
            end
            clear_parse_state();
        end
    endfunction

    // Offers one word on the s_ channel, maybe after a random gap, and waits for the
    // handshake. Valid is not lowered after acceptance unless a gap follows, so a
    // back-to-back word never sees two assignments to s_valid in one time step.
    task automatic feed_byte(input logic [BYTE_W-1:0] data, input logic last,
                             input logic typed, input report_total_t typed_result);
        logic          has_result;
        report_total_t predicted;
        if (idle_roll()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (idle_roll());
        end
        s_valid           <= 1'b1;
        s_descriptor_byte <= data;
        s_final_byte      <= last;
        do @(posedge aclk); while (!s_ready);
        advance_parse(data, last, has_result, predicted);
        if (has_result) pending_totals.push_back(typed ? typed_result : predicted);
    endtask

    // Short item with a random size code; the data bytes are the value's low bytes.
    task automatic push_short_item(input logic [TAG_W-1:0] tag, input logic [1:0] kind,
                                   input logic [31:0] value);
        int         roll;
        int         len;
        logic [1:0] code;
        roll = $urandom_range(0, 9);
        code = (roll == 0) ? SIZE_CODE_NONE : (roll <= 6) ? 2'd1 :
               (roll <= 8) ? 2'd2 : SIZE_CODE_FOUR;
        len  = (code == SIZE_CODE_FOUR) ? 4 : int'(code);
        descriptor_bytes.push_back({tag, kind, code});
        for (int i = 0; i < len; i++) descriptor_bytes.push_back(value[8*i +: 8]);
    endtask

    // Builds one descriptor, mostly well-formed items with random content, some noise,
    // and now and then a cut at a random point or a dangling item header.
    task automatic build_descriptor();
        int               items;
        int               pick;
        int               cut;
        int               len;
        logic [31:0]      value;
        logic [TAG_W-1:0] tag;
        descriptor_bytes.delete();
        items = $urandom_range(2, 14);
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                value = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 32) : $urandom;
                push_short_item(TAG_REPORT_SIZE, TYPE_GLOBAL, value);
            end else if (pick < 36) begin
                value = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom;
                push_short_item(TAG_REPORT_COUNT, TYPE_GLOBAL, value);
            end else if (pick < 46) begin
                case ($urandom_range(0, 3))
                    0, 1:    value = {24'd0, want_report_id};
                    2:       value = $urandom_range(0, 3);
                    default: value = $urandom;
                endcase
                push_short_item(TAG_REPORT_ID, TYPE_GLOBAL, value);
            end else if (pick < 78) begin
                tag = ($urandom_range(0, 1) == 1) ? want_main_tag : 4'($urandom);
                push_short_item(tag, TYPE_MAIN, $urandom);
            end else if (pick < 84) begin
                len = $urandom_range(0, 6);
                descriptor_bytes.push_back(LONG_PREFIX);
                descriptor_bytes.push_back(8'(len));
                descriptor_bytes.push_back(8'($urandom));
                repeat (len) descriptor_bytes.push_back(8'($urandom));
            end else if (pick < 92) begin
                // Local and reserved types land here as well as the rest.
                push_short_item(4'($urandom), 2'($urandom), $urandom);
            end else begin
                descriptor_bytes.push_back(8'($urandom));
            end
        end
        case ($urandom_range(0, 9))
            8: begin
                cut = $urandom_range(1, descriptor_bytes.size());
                while (descriptor_bytes.size() > cut) void'(descriptor_bytes.pop_back());
            end
            9: descriptor_bytes.push_back({4'($urandom), TYPE_LOCAL, SIZE_CODE_FOUR});
            default: ;
        endcase
    endtask

    // Every register write happens here, with the block idle. The spare index gets a
    // random value that must change nothing.
    task automatic program_filter(input logic [BYTE_W-1:0] id_data,
                                  input logic [BYTE_W-1:0] tag_data);
        logic [CFG_IDX_W-1:0] spare_index;
        logic [BYTE_W-1:0]    spare_data;
        spare_index = ($urandom_range(0, 1) == 1) ? CFG_IDX_SPARE_2 : CFG_IDX_SPARE_3;
        spare_data  = 8'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_REPORT_ID;
        cfg_wdata <= id_data;
        @(posedge aclk);
        cfg_index <= CFG_IDX_MAIN_TAG;
        cfg_wdata <= tag_data;
        @(posedge aclk);
        cfg_index <= spare_index;
        cfg_wdata <= spare_data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        set_register(CFG_IDX_REPORT_ID, id_data);
        set_register(CFG_IDX_MAIN_TAG, tag_data);
        set_register(spare_index, spare_data);
    endtask

    // Waits until every owed word has come back, then lets the pipeline empty.
    task automatic wait_for_drain(input int extra_cycles);
        s_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge aclk);
        repeat (extra_cycles) @(posedge aclk);
    endtask

    // Result side: random stalls on m_ready, and an in-order check of every word taken.
    always @(posedge aclk) begin
        report_total_t want;
        m_ready <= !idle_roll();
        if (m_valid && m_ready) begin
            if (pending_totals.size() == 0) begin
                $display("%0t: unexpected word, expected none, got total %h truncated %b",
                         $time, m_report_bit_total, m_truncated);
                fail_count++;
            end else begin
                want = pending_totals.pop_front();
                if (m_report_bit_total !== want.total) begin
                    $display("%0t: report_bit_total expected %h, got %h",
                             $time, want.total, m_report_bit_total);
                    fail_count++;
                end
                if (m_truncated !== want.trunc) begin
                    $display("%0t: truncated expected %b, got %b",
                             $time, want.trunc, m_truncated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d words outstanding",
                     $time, pending_totals.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence: reset, the directed table under the reset filter, then five phases of random
    // descriptors, the first still under the reset filter and each later one under its own setting.
    // The setting extremes come first, and one phase runs with no idling on either side.
    initial begin
        report_total_t typed_result;
        int            sent;
        int            budget;
        want_report_id = RESET_REPORT_ID;
        want_main_tag  = RESET_MAIN_TAG;
        clear_parse_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            typed_result.total = DIRECTED[i].total;
            typed_result.trunc = DIRECTED[i].trunc;
            feed_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, typed_result);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                wait_for_drain(DRAIN_CYCLES);
                // The upper nibble of the tag write is junk that the block must mask off.
                case (phase)
                    1: program_filter(8'hFF, {4'($urandom), 4'hF});
                    2: program_filter(8'h00, {4'($urandom), 4'h0});
                    3: program_filter(8'($urandom), {4'($urandom), MAIN_TAG_OUTPUT});
                    default: program_filter(8'($urandom_range(1, 3)),
                                            {4'($urandom), MAIN_TAG_FEATURE});
                endcase
            end
            steady_flow <= (phase == 2);
            budget = (phase == 0) ? 180 : 210;
            sent   = 0;
            while (sent < budget) begin
                build_descriptor();
                foreach (descriptor_bytes[j]) begin
                    feed_byte(descriptor_bytes[j], j == descriptor_bytes.size() - 1,
                              1'b0, '0);
                end
                sent += descriptor_bytes.size();
            end
        end

        wait_for_drain(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
